// File: rtl/core/lms_adaptive_echo_canceller_assert.svh
// Assertion macros used by the echo canceller sequencer.
`ifndef LMS_ADAPTIVE_ECHO_CANCELLER_ASSERT_SVH
`define LMS_ADAPTIVE_ECHO_CANCELLER_ASSERT_SVH

`ifndef SYNTHESIS
// Checked while out of reset.
`define LMSAEC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lmsaec assertion failed");
// Checked on every edge, reset included.
`define LMSAEC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("lmsaec reset assertion failed");
`else
`define LMSAEC_ASSERT(label, prop)
`define LMSAEC_ASSERT_ALWAYS(label, prop)
`endif

`endif

// File: rtl/core/lmsaec_pkg.sv
`default_nettype none

package lmsaec_pkg;

  // Filter length and derived widths
  localparam int TAP_COUNT = 32;
  localparam int TAP_IDX_W = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  // Sum of TAP_COUNT saturated Q31 products
  localparam int ACC_W     = 32 + TAP_IDX_W;

  // Q31 constants
  localparam logic [30:0] STEP_RESET = 31'h0A3D70A4;
  localparam logic [62:0] Q31_HALF   = 63'd1073741824;
  localparam logic [31:0] Q31_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] Q31_MIN    = 32'h8000_0000;

  // What the shared multiplier is working on
  typedef enum logic [1:0] {
    MODE_FILT,
    MODE_GAIN,
    MODE_UPD
  } mac_mode_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_FILT,
    S_FDRAIN,
    S_EST,
    S_ERR,
    S_GMUL,
    S_GWAIT,
    S_UPD,
    S_UDRAIN,
    S_OUT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic      load_in;
    logic      issue;
    mac_mode_t mode;
    logic      est_ld;
    logic      err_ld;
    logic      out_ld;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic busy;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/lmsaec_dp.sv
`default_nettype none

module lmsaec_dp (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire lmsaec_pkg::dp_cmd_t cmd,
  output lmsaec_pkg::dp_sts_t     sts,
  input  wire logic signed [31:0] in_reference_sample,
  input  wire logic signed [31:0] in_mic_sample,
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [30:0]        cfg_step_size,
  output logic signed [31:0]      out_error_sample
);

  localparam int N  = lmsaec_pkg::TAP_COUNT;
  localparam int AW = lmsaec_pkg::ACC_W;

  // Tap history and weights, both rotated so tap i passes entry 0 in order
  logic [31:0] hist_r [N];
  logic [31:0] w_r    [N];

  logic [30:0]   step_r;
  logic [31:0]   mic_r;
  logic [AW-1:0] acc_r;
  logic [31:0]   est_r;
  logic [31:0]   err_r;
  logic [31:0]   g_r;
  logic [31:0]   out_r;

  // Multiplier pipeline
  logic                  v1_r, v2_r;
  lmsaec_pkg::mac_mode_t m1_r, m2_r;
  logic                  neg1_r;
  logic [62:0]           prod_r;
  logic [31:0]           q_r;

  logic [31:0] op_a, op_b, mag_a, mag_b;
  logic [63:0] prod_full;
  logic [62:0] rnd_sum;
  logic [31:0] rnd, q_nxt;
  logic [32:0] wsum;
  logic [31:0] wsat;
  logic [32:0] diff;
  logic [31:0] est_nxt, err_nxt;
  logic        acc_fits;

  assign cfg_ready        = 1'b1;
  assign out_error_sample = out_r;
  assign sts.busy         = v1_r | v2_r;

  // Operand select for the shared multiplier
  always_comb begin
    unique case (cmd.mode)
      lmsaec_pkg::MODE_FILT: begin
        op_a = hist_r[0];
        op_b = w_r[0];
      end
      lmsaec_pkg::MODE_GAIN: begin
        op_a = {1'b0, step_r};
        op_b = err_r;
      end
      lmsaec_pkg::MODE_UPD: begin
        op_a = g_r;
        op_b = hist_r[0];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Stage 1: magnitude product
  assign mag_a     = op_a[31] ? (~op_a + 32'd1) : op_a;
  assign mag_b     = op_b[31] ? (~op_b + 32'd1) : op_b;
  assign prod_full = {32'd0, mag_a} * {32'd0, mag_b};

  // Stage 2: round half away from zero, clamp, restore sign
  assign rnd_sum = prod_r + lmsaec_pkg::Q31_HALF;
  assign rnd     = rnd_sum[62:31];
  always_comb begin
    if (neg1_r) begin
      q_nxt = (rnd > lmsaec_pkg::Q31_MIN) ? lmsaec_pkg::Q31_MIN : (~rnd + 32'd1);
    end else begin
      q_nxt = (rnd > lmsaec_pkg::Q31_MAX) ? lmsaec_pkg::Q31_MAX : rnd;
    end
  end

  // Stage 3 helper: saturating weight add
  assign wsum = {w_r[0][31], w_r[0]} + {q_r[31], q_r};
  assign wsat = (wsum[32] != wsum[31]) ?
                (wsum[32] ? lmsaec_pkg::Q31_MIN : lmsaec_pkg::Q31_MAX) : wsum[31:0];

  // Estimate saturation from the wide accumulator
  assign acc_fits = (acc_r[AW-1:31] == '0) || (acc_r[AW-1:31] == '1);
  assign est_nxt  = acc_fits ? acc_r[31:0] :
                    (acc_r[AW-1] ? lmsaec_pkg::Q31_MIN : lmsaec_pkg::Q31_MAX);

  // Error = mic - estimate, saturated
  assign diff    = {mic_r[31], mic_r} - {est_r[31], est_r};
  assign err_nxt = (diff[32] != diff[31]) ?
                   (diff[32] ? lmsaec_pkg::Q31_MIN : lmsaec_pkg::Q31_MAX) : diff[31:0];

  // State arrays, step register and pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        hist_r[i] <= '0;
        w_r[i]    <= '0;
      end
      step_r <= lmsaec_pkg::STEP_RESET;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        step_r <= cfg_step_size;
      end

      // history: shift in on transfer, rotate while taps are issued
      if (cmd.load_in) begin
        for (int i = N - 1; i > 0; i--) hist_r[i] <= hist_r[i-1];
        hist_r[0] <= in_reference_sample;
      end else if (cmd.issue && cmd.mode != lmsaec_pkg::MODE_GAIN) begin
        for (int i = 0; i < N - 1; i++) hist_r[i] <= hist_r[i+1];
        hist_r[N-1] <= hist_r[0];
      end

      // weights: rotate in filter pass, shift in updated value in update pass
      if (cmd.issue && cmd.mode == lmsaec_pkg::MODE_FILT) begin
        for (int i = 0; i < N - 1; i++) w_r[i] <= w_r[i+1];
        w_r[N-1] <= w_r[0];
      end else if (v2_r && m2_r == lmsaec_pkg::MODE_UPD) begin
        for (int i = 0; i < N - 1; i++) w_r[i] <= w_r[i+1];
        w_r[N-1] <= wsat;
      end

      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    m1_r   <= cmd.mode;
    neg1_r <= op_a[31] ^ op_b[31];
    prod_r <= prod_full[62:0];
    m2_r   <= m1_r;
    q_r    <= q_nxt;

    if (cmd.load_in) begin
      mic_r <= in_mic_sample;
      acc_r <= '0;
    end else if (v2_r && m2_r == lmsaec_pkg::MODE_FILT) begin
      acc_r <= acc_r + {{(AW-32){q_r[31]}}, q_r};
    end

    if (v2_r && m2_r == lmsaec_pkg::MODE_GAIN) g_r <= q_r;
    if (cmd.est_ld) est_r <= est_nxt;
    if (cmd.err_ld) err_r <= err_nxt;
    if (cmd.out_ld) out_r <= err_r;
  end

endmodule

`default_nettype wire

// File: rtl/core/lmsaec_ctrl.sv
`default_nettype none

`include "lms_adaptive_echo_canceller_assert.svh"

module lmsaec_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  output lmsaec_pkg::dp_cmd_t cmd,
  input  wire lmsaec_pkg::dp_sts_t sts
);

  localparam int CW = lmsaec_pkg::TAP_IDX_W;

  lmsaec_pkg::ctrl_state_t state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    last_tap;

  assign last_tap  = (cnt_r == CW'(lmsaec_pkg::TAP_COUNT - 1));
  assign in_ready  = (state_r == lmsaec_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lmsaec_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.mode  = lmsaec_pkg::MODE_FILT;

    unique case (state_r)
      lmsaec_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = lmsaec_pkg::S_FILT;
        end
      end
      lmsaec_pkg::S_FILT: begin
        cmd.issue = 1'b1;
        cmd.mode  = lmsaec_pkg::MODE_FILT;
        cnt_nxt   = cnt_r + CW'(1);
        if (last_tap) state_nxt = lmsaec_pkg::S_FDRAIN;
      end
      lmsaec_pkg::S_FDRAIN: begin
        if (!sts.busy) state_nxt = lmsaec_pkg::S_EST;
      end
      lmsaec_pkg::S_EST: begin
        cmd.est_ld = 1'b1;
        state_nxt  = lmsaec_pkg::S_ERR;
      end
      lmsaec_pkg::S_ERR: begin
        cmd.err_ld = 1'b1;
        state_nxt  = lmsaec_pkg::S_GMUL;
      end
      lmsaec_pkg::S_GMUL: begin
        cmd.issue = 1'b1;
        cmd.mode  = lmsaec_pkg::MODE_GAIN;
        state_nxt = lmsaec_pkg::S_GWAIT;
      end
      lmsaec_pkg::S_GWAIT: begin
        if (!sts.busy) begin
          cnt_nxt   = '0;
          state_nxt = lmsaec_pkg::S_UPD;
        end
      end
      lmsaec_pkg::S_UPD: begin
        cmd.issue = 1'b1;
        cmd.mode  = lmsaec_pkg::MODE_UPD;
        cnt_nxt   = cnt_r + CW'(1);
        if (last_tap) state_nxt = lmsaec_pkg::S_UDRAIN;
      end
      lmsaec_pkg::S_UDRAIN: begin
        if (!sts.busy) state_nxt = lmsaec_pkg::S_OUT;
      end
      lmsaec_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_ld = 1'b1;
          state_nxt  = lmsaec_pkg::S_IDLE;
        end
      end
      default: state_nxt = lmsaec_pkg::S_IDLE;
    endcase

    // output register valid
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  `LMSAEC_ASSERT_ALWAYS(a_rst_idle,
    !rst_n |=> (state_r == lmsaec_pkg::S_IDLE && !out_valid_r))
  `LMSAEC_ASSERT(a_accept_starts,
    (in_valid && in_ready) |=> (state_r == lmsaec_pkg::S_FILT && cnt_r == '0))
  `LMSAEC_ASSERT(a_issue_state,
    cmd.issue |-> (state_r == lmsaec_pkg::S_FILT || state_r == lmsaec_pkg::S_GMUL ||
                   state_r == lmsaec_pkg::S_UPD))
  `LMSAEC_ASSERT(a_est_drained, (state_r == lmsaec_pkg::S_EST) |-> !sts.busy)
  `LMSAEC_ASSERT(a_out_no_overwrite, cmd.out_ld |-> (!out_valid_r || out_ready))

endmodule

`default_nettype wire

// File: rtl/core/lms_adaptive_echo_canceller.sv
// After the input transfer come the filter pass, its drain, the estimate and error loads, the gain
// multiply, the update pass, its drain and the output load; no new sample is taken until they are done.
//   The single shared 32x32 multiplier passes over all taps for the estimate, then for the update.
// A finished result waits in the output register while the next item is taken in.
// Reset (rst_n low, synchronous): history and weights cleared, step size back to its default.
`default_nettype none

module lms_adaptive_echo_canceller (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_reference_sample,
  input  wire logic signed [31:0] in_mic_sample,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic signed [31:0]      out_error_sample,
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [30:0]        cfg_step_size
);

  lmsaec_pkg::dp_cmd_t cmd;
  lmsaec_pkg::dp_sts_t sts;

  // Sequencer
  lmsaec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Taps, multiplier pipeline and result registers
  lmsaec_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_reference_sample (in_reference_sample),
    .in_mic_sample       (in_mic_sample),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_step_size       (cfg_step_size),
    .out_error_sample    (out_error_sample)
  );

endmodule

`default_nettype wire

// File: tb/sv/lms_aec_checker.sv
module lms_aec_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] in_reference_sample,
  input  logic signed [31:0] in_mic_sample,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_error_sample,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [30:0]        cfg_step_size,
  output int                 mismatch_count,
  output int                 errors_checked,
  output int                 results_pending
);

  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;
  localparam longint ROUND_HALF = 64'sd1073741824;

  // Shadow copy of the filter state
  logic signed [31:0] far_hist [lmsaec_pkg::TAP_COUNT];
  logic signed [31:0] coeff [lmsaec_pkg::TAP_COUNT];
  logic [30:0]        mu;
  logic signed [31:0] error_q [$];

  initial begin
    mismatch_count  = 0;
    errors_checked  = 0;
    results_pending = 0;
  end

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > S32_HI) return 32'sh7FFF_FFFF;
    if (v < S32_LO) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Q31 product, rounded half away from zero, saturated
  function automatic logic signed [31:0] q31_product(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
    longint ma;
    longint mb;
    longint r;
    ma = (a < 0) ? -longint'(a) : longint'(a);
    mb = (b < 0) ? -longint'(b) : longint'(b);
    r  = (ma * mb + ROUND_HALF) >>> 31;
    if ((a < 0) != (b < 0)) return clamp32(-r);
    return clamp32(r);
  endfunction

  // One sample: shift history, estimate echo, form error, adapt weights
  function automatic logic signed [31:0] cancel_and_adapt(input logic signed [31:0] far,
                                                          input logic signed [31:0] near);
    longint             acc;
    logic signed [31:0] est;
    logic signed [31:0] err;
    logic signed [31:0] gain;
    for (int i = lmsaec_pkg::TAP_COUNT - 1; i > 0; i--) far_hist[i] = far_hist[i-1];
    far_hist[0] = far;
    acc = 0;
    for (int i = 0; i < lmsaec_pkg::TAP_COUNT; i++)
      acc += longint'(q31_product(far_hist[i], coeff[i]));
    est  = clamp32(acc);
    err  = clamp32(longint'(near) - longint'(est));
    gain = q31_product($signed({1'b0, mu}), err);
    for (int i = 0; i < lmsaec_pkg::TAP_COUNT; i++)
      coeff[i] = clamp32(longint'(coeff[i]) + longint'(q31_product(gain, far_hist[i])));
    return err;
  endfunction

  always @(posedge clk) begin
    logic signed [31:0] want;
    if (!rst_n) begin
      for (int i = 0; i < lmsaec_pkg::TAP_COUNT; i++) begin
        far_hist[i] = '0;
        coeff[i]    = '0;
      end
      mu = lmsaec_pkg::STEP_RESET;
      error_q.delete();
    end else begin
      // step size write
      if (cfg_valid && cfg_ready) mu = cfg_step_size;

      // result transfer: compare against the oldest prediction
      if (out_valid && out_ready) begin
        if (error_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected error_sample transfer, expected none, actual %0d",
                   $time, out_error_sample);
        end else begin
          want = error_q.pop_front();
          errors_checked++;
          if (out_error_sample !== want) begin
            mismatch_count++;
            $display("%0t: error_sample mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
                     $time, want, want, out_error_sample, out_error_sample);
          end
        end
      end

      // sample transfer: predict its error
      if (in_valid && in_ready)
        error_q.push_back(cancel_and_adapt(in_reference_sample, in_mic_sample));
    end
    results_pending <= error_q.size();
  end

endmodule

// File: tb/sv/tb_lms_adaptive_echo_canceller.sv
module tb_lms_adaptive_echo_canceller;

  localparam int IDLE_LIMIT   = 5000;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 100;
  localparam logic signed [31:0] FULL_POS = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] FULL_NEG = 32'sh8000_0000;
  localparam logic [30:0]        STEP_MAX = 31'h7FFF_FFFF;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_reference_sample = '0;
  logic signed [31:0] in_mic_sample = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_error_sample;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [30:0]        cfg_step_size = '0;

  int mismatch_count;
  int errors_checked;
  int results_pending;

  int samples_sent = 0;
  int step_writes = 0;
  int hold_offs = 0;
  int idle_cycles = 0;
  bit steady_flow = 1'b0;
  logic signed [31:0] far_log [$];

  lms_adaptive_echo_canceller u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_reference_sample (in_reference_sample),
    .in_mic_sample       (in_mic_sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_error_sample    (out_error_sample),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_step_size       (cfg_step_size)
  );

  lms_aec_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_reference_sample (in_reference_sample),
    .in_mic_sample       (in_mic_sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_error_sample    (out_error_sample),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_step_size       (cfg_step_size),
    .mismatch_count      (mismatch_count),
    .errors_checked      (errors_checked),
    .results_pending     (results_pending)
  );

  always #5 clk = ~clk;

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 150);
  endfunction

  function automatic logic signed [31:0] random_q31();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return FULL_NEG;
          1: return FULL_POS;
          2: return -32'sd1;
          3: return 32'sd0;
          default: return 32'sd1;
        endcase
      end
      1, 2, 3, 4, 5: return $urandom;
      default: return $signed($urandom) >>> $urandom_range(4, 24);
    endcase
  endfunction

  // Offer one sample; returns at the edge of its transfer
  task automatic send_sample(input logic signed [31:0] far, input logic signed [31:0] near);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_reference_sample <= far;
    in_mic_sample       <= near;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  // Stop offering and wait for every predicted error to come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  task automatic write_step(input logic [30:0] mu);
    cfg_valid     <= 1'b1;
    cfg_step_size <= mu;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    step_writes++;
  endtask

  // Mostly echo-like near-end (delayed, attenuated far-end plus noise), rest unrelated
  task automatic play_random(input int n);
    logic signed [31:0] far;
    logic signed [31:0] near;
    int                 lag;
    for (int k = 0; k < n; k++) begin
      far = random_q31();
      far_log.push_front(far);
      if (far_log.size() > lmsaec_pkg::TAP_COUNT) void'(far_log.pop_back());
      if ($urandom_range(0, 3) != 0) begin
        lag  = $urandom_range(0, far_log.size() - 1);
        near = (far_log[lag] >>> $urandom_range(1, 4))
               + ($signed($urandom) >>> $urandom_range(8, 30));
      end else begin
        near = random_q31();
      end
      send_sample(far, near);
    end
  endtask

  task automatic run_phase(input logic [30:0] mu, input int n);
    wait_drained();
    write_step(mu);
    play_random(n);
  endtask

  // Stimulus
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes at the default step size
    send_sample(32'sd0, 32'sd0);
    send_sample(FULL_POS, FULL_POS);
    send_sample(FULL_NEG, FULL_NEG);
    send_sample(FULL_POS, FULL_NEG);
    send_sample(FULL_NEG, FULL_POS);
    send_sample(32'sd1, -32'sd1);
    send_sample(-32'sd1, 32'sd1);

    // full step: drive weights to negative full scale, then overflow estimate and error
    wait_drained();
    write_step(STEP_MAX);
    repeat (10) send_sample(FULL_NEG, FULL_POS);
    repeat (4) send_sample(FULL_NEG, FULL_NEG);
    repeat (2) send_sample(FULL_POS, FULL_NEG);

    // random phases over several step sizes
    run_phase(31'($urandom_range(1, 1 << 24)), 100);
    run_phase(31'd0, 100);
    steady_flow = 1'b1;
    run_phase(lmsaec_pkg::STEP_RESET, 100);
    steady_flow = 1'b0;
    run_phase(STEP_MAX, 100);
    run_phase(31'($urandom), 100);
    run_phase(31'($urandom_range(1 << 20, 1 << 28)), 100);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d samples, %0d step size writes, %0d error samples checked,",
             samples_sent, step_writes, errors_checked);
    $display("with %0d long output hold-offs and directed full-scale saturation cases.",
             hold_offs);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: random stalls, plus long hold-offs so the block backs up
  initial begin
    int gap;
    int taken;
    taken = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken == 60 || taken == 350) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_offs++;
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Watchdog: cycles with no transfer on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
